// ===== hdl/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types, register indexes and per-sample-type constants for the
// pixel contrast to RGBA8 converter.
// ----------------------------------------------------------------------------
package pcr_pkg;

   localparam int unsigned LANES      = 4;
   localparam int unsigned SAMPLE_W   = 32;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned PROD_W     = 48;   // 32 x 16 signed product
   localparam int unsigned OFS_W      = 24;   // offset * 255
   localparam int unsigned SUM_W      = 49;   // product + offset term
   localparam int unsigned SCALE_W    = 51;   // 255 * in-range sum
   localparam int unsigned QUOT_W     = 39;   // scaled sum >> 12
   localparam int unsigned MAX_W      = 31;   // widest type maximum
   localparam int unsigned FRAC_BITS  = 12;   // Q4.12

   typedef enum logic [1:0] {
      TYPE_U8  = 2'd0,
      TYPE_U16 = 2'd1,
      TYPE_S16 = 2'd2,
      TYPE_S32 = 2'd3
   } sample_type_type;

   typedef enum logic [2:0] {
      CSR_SAMPLE_TYPE     = 3'd0,
      CSR_CHANNEL_COUNT   = 3'd1,
      CSR_CHANNEL_GAINS   = 3'd2,
      CSR_CHANNEL_OFFSETS = 3'd3,
      CSR_LAYOUT_MAP      = 3'd4
   } csr_index_type;

   // Stage load enables handed from the pipeline control to each lane.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

   // Largest sample value of each type; every one is 2^k - 1.
   function automatic logic [MAX_W-1:0] type_max(sample_type_type st);
      logic [MAX_W-1:0] m;
      unique case (st)
         TYPE_U8:  m = MAX_W'(32'h0000_00FF);
         TYPE_U16: m = MAX_W'(32'h0000_FFFF);
         TYPE_S16: m = MAX_W'(32'h0000_7FFF);
         TYPE_S32: m = MAX_W'(32'h7FFF_FFFF);
         default:  m = '0;
      endcase
      return m;
   endfunction

   // Sum at and above which the output saturates: max * 4096.
   function automatic logic [SUM_W-1:0] type_limit(sample_type_type st);
      return SUM_W'(type_max(st)) << FRAC_BITS;
   endfunction

endpackage

// ===== hdl/pcr_lane.sv =====
// ----------------------------------------------------------------------------
// pcr_lane
// One channel of the normalizer: decode, gain multiply, offset add, scale by
// 255 / type maximum with truncation, clamp to 0..255. Four register stages.
// ----------------------------------------------------------------------------
module pcr_lane (
   input  logic                                    clock,
   input  pcr_pkg::adv_type                        adv,
   input  pcr_pkg::sample_type_type                sample_type,
   input  logic [pcr_pkg::SAMPLE_W-1:0]            sample,
   input  logic signed [pcr_pkg::COEF_W-1:0]       gain,
   input  logic signed [pcr_pkg::COEF_W-1:0]       offset,
   output logic [pcr_pkg::BYTE_W-1:0]              level
);

   logic signed [pcr_pkg::SAMPLE_W-1:0] decoded;
   logic signed [pcr_pkg::PROD_W-1:0]   prod_in, prod_ff;
   logic signed [pcr_pkg::OFS_W-1:0]    ofs_ext;
   logic signed [pcr_pkg::OFS_W-1:0]    ofs_in, ofs_ff;
   logic signed [pcr_pkg::SUM_W-1:0]    sum_in, sum_ff;
   logic [pcr_pkg::SCALE_W-1:0]         sum_lo, scaled;
   logic [pcr_pkg::QUOT_W-1:0]          quot_in, quot_ff;
   logic                                nonpos_in, nonpos_ff;
   logic                                sat_in, sat_ff;
   logic [pcr_pkg::BYTE_W-1:0]          q0;
   logic [pcr_pkg::MAX_W-1:0]           low;
   logic [pcr_pkg::MAX_W:0]             rem;
   logic [pcr_pkg::BYTE_W-1:0]          level_in, level_ff;

   // Stage 1: decode the sample and multiply by the gain.
   always_comb begin
      unique case (sample_type)
         pcr_pkg::TYPE_U8:  decoded = $signed(pcr_pkg::SAMPLE_W'(sample[7:0]));
         pcr_pkg::TYPE_U16: decoded = $signed(pcr_pkg::SAMPLE_W'(sample[15:0]));
         pcr_pkg::TYPE_S16: decoded = pcr_pkg::SAMPLE_W'($signed(sample[15:0]));
         pcr_pkg::TYPE_S32: decoded = $signed(sample);
         default:           decoded = '0;
      endcase
   end

   assign prod_in = decoded * gain;
   assign ofs_ext = pcr_pkg::OFS_W'(offset);
   assign ofs_in  = (ofs_ext <<< 8) - ofs_ext;

   // Stage 2: add the offset term.
   assign sum_in = pcr_pkg::SUM_W'(prod_ff) + pcr_pkg::SUM_W'(ofs_ff);

   // Stage 3: classify the sum and scale by 255, drop the Q4.12 fraction.
   assign nonpos_in = sum_ff[pcr_pkg::SUM_W-1] || (sum_ff == '0);
   assign sat_in    = sum_ff >= $signed(pcr_pkg::type_limit(sample_type));
   assign sum_lo    = pcr_pkg::SCALE_W'(sum_ff[42:0]);
   assign scaled    = (sum_lo << 8) - sum_lo;
   assign quot_in   = scaled[pcr_pkg::SCALE_W-1:pcr_pkg::FRAC_BITS];

   // Stage 4: divide by 2^k - 1 as shift plus one correction step.
   always_comb begin
      unique case (sample_type)
         pcr_pkg::TYPE_U8: begin
            q0  = quot_ff[15:8];
            low = pcr_pkg::MAX_W'(quot_ff[7:0]);
         end
         pcr_pkg::TYPE_U16: begin
            q0  = quot_ff[23:16];
            low = pcr_pkg::MAX_W'(quot_ff[15:0]);
         end
         pcr_pkg::TYPE_S16: begin
            q0  = quot_ff[22:15];
            low = pcr_pkg::MAX_W'(quot_ff[14:0]);
         end
         pcr_pkg::TYPE_S32: begin
            q0  = quot_ff[38:31];
            low = quot_ff[30:0];
         end
         default: begin
            q0  = '0;
            low = '0;
         end
      endcase
      rem = (pcr_pkg::MAX_W+1)'(low) + (pcr_pkg::MAX_W+1)'(q0);
      priority if (nonpos_ff) begin
         level_in = '0;
      end else if (sat_ff) begin
         level_in = '1;
      end else begin
         level_in = q0 + pcr_pkg::BYTE_W'(
            rem >= (pcr_pkg::MAX_W+1)'(pcr_pkg::type_max(sample_type)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_ff <= prod_in;
         ofs_ff  <= ofs_in;
      end
      if (adv.s2) begin
         sum_ff <= sum_in;
      end
      if (adv.s3) begin
         nonpos_ff <= nonpos_in;
         sat_ff    <= sat_in;
         quot_ff   <= quot_in;
      end
      if (adv.s4) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

// ===== hdl/pcr_merge.sv =====
// ----------------------------------------------------------------------------
// pcr_merge
// Combines the lane levels: masks inactive channels (alpha to 255), copies a
// single gray channel, places bytes by the layout map. Output register.
// ----------------------------------------------------------------------------
module pcr_merge (
   input  logic                                            clock,
   input  logic                                            load,
   input  logic [pcr_pkg::LANES-1:0][pcr_pkg::BYTE_W-1:0]  lane_level,
   input  logic [2:0]                                      channel_count,
   input  logic [7:0]                                      layout_map,
   input  logic                                            frame_end,
   output logic [pcr_pkg::LANES-1:0][pcr_pkg::BYTE_W-1:0]  out_bytes,
   output logic                                            frame_end_out
);

   logic [2:0]                                     active;
   logic [pcr_pkg::LANES-1:0][pcr_pkg::BYTE_W-1:0] px;
   logic [pcr_pkg::LANES-1:0][pcr_pkg::BYTE_W-1:0] bytes_in, bytes_ff;
   logic                                           frame_end_ff;

   always_comb begin
      active = (channel_count > 3'd4) ? 3'd4 : channel_count;
      for (int c = 0; c < pcr_pkg::LANES; c++) begin
         if (3'(c) < active) begin
            px[c] = lane_level[c];
         end else if (c == pcr_pkg::LANES - 1) begin
            px[c] = '1;
         end else begin
            px[c] = '0;
         end
      end
      // Gray input: replicate into G and B.
      if (active == 3'd1) begin
         px[1] = px[0];
         px[2] = px[0];
      end
      // Later channels win on a collision.
      bytes_in = '0;
      for (int c = 0; c < pcr_pkg::LANES; c++) begin
         bytes_in[layout_map[2*c +: 2]] = px[c];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff     <= bytes_in;
         frame_end_ff <= frame_end;
      end
   end

   assign out_bytes     = bytes_ff;
   assign frame_end_out = frame_end_ff;

endmodule

// ===== hdl/pixel_contrast_to_rgba8_top.sv =====
// ----------------------------------------------------------------------------
// pixel_contrast_to_rgba8_top
// Brightness/contrast normalization of one pixel of up to four samples into
// four RGBA8 bytes, four channel lanes side by side plus a merging stage.
//
// Path: an accepted word passes the four lane stages and then the merge output
// register, which presents it on rsp_ until the response handshake.
// Throughput: one word per cycle unless rsp_ready stalls the output; the
// four lane stages and the output register each hold one word, so the input
// keeps flowing into empty stages while a finished word waits on rsp_ready.
// Reset: synchronous, active high; empties the pipeline and returns all
// configuration registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module pixel_contrast_to_rgba8_top (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pcr_pkg::SAMPLE_W-1:0]    req_sample_0,
   input  logic [pcr_pkg::SAMPLE_W-1:0]    req_sample_1,
   input  logic [pcr_pkg::SAMPLE_W-1:0]    req_sample_2,
   input  logic [pcr_pkg::SAMPLE_W-1:0]    req_sample_3,
   input  logic                            req_frame_end,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pcr_pkg::BYTE_W-1:0]      rsp_out_byte_0,
   output logic [pcr_pkg::BYTE_W-1:0]      rsp_out_byte_1,
   output logic [pcr_pkg::BYTE_W-1:0]      rsp_out_byte_2,
   output logic [pcr_pkg::BYTE_W-1:0]      rsp_out_byte_3,
   output logic                            rsp_frame_end_out,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [63:0]                     csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   pcr_pkg::sample_type_type sample_type_ff;
   logic [2:0]               channel_count_ff;
   logic [63:0]              channel_gains_ff;
   logic [63:0]              channel_offsets_ff;
   logic [7:0]               layout_map_ff;

   // Always take a write; the user must write only while idle (not enforced).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_type_ff     <= pcr_pkg::TYPE_U8;
         channel_count_ff   <= 3'd1;
         channel_gains_ff   <= 64'h1000_1000_1000_1000;
         channel_offsets_ff <= '0;
         layout_map_ff      <= 8'hE4;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcr_pkg::CSR_SAMPLE_TYPE: begin
               sample_type_ff <= pcr_pkg::sample_type_type'(csr_wdata[1:0]);
            end
            pcr_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_ff <= csr_wdata[2:0];
            end
            pcr_pkg::CSR_CHANNEL_GAINS: begin
               channel_gains_ff <= csr_wdata;
            end
            pcr_pkg::CSR_CHANNEL_OFFSETS: begin
               channel_offsets_ff <= csr_wdata;
            end
            pcr_pkg::CSR_LAYOUT_MAP: begin
               layout_map_ff <= csr_wdata[7:0];
            end
            default: begin
               // Unmapped index: drop the write.
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: each stage loads whenever it is empty or its word
   // moves on, so bubbles close up even while the output is stalled.
   // ---------------------------------------------------------------------
   logic            v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff;
   logic            v1_in, v2_in, v3_in, v4_in, out_valid_in;
   logic            rdy1, rdy2, rdy3, rdy4, rdy_out;
   logic            fe1_ff, fe2_ff, fe3_ff, fe4_ff;
   pcr_pkg::adv_type adv;

   assign rdy_out = !out_valid_ff || rsp_ready;
   assign rdy4    = !v4_ff || rdy_out;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;

   assign req_ready = rdy1;

   // Load a stage's payload only when a real word moves into it.
   assign adv.s1 = rdy1 && req_valid;
   assign adv.s2 = rdy2 && v1_ff;
   assign adv.s3 = rdy3 && v2_ff;
   assign adv.s4 = rdy4 && v3_ff;

   assign v1_in        = rdy1    ? req_valid : v1_ff;
   assign v2_in        = rdy2    ? v1_ff     : v2_ff;
   assign v3_in        = rdy3    ? v2_ff     : v3_ff;
   assign v4_in        = rdy4    ? v3_ff     : v4_ff;
   assign out_valid_in = rdy_out ? v4_ff     : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Frame marker rides alongside the lane stages.
   always_ff @(posedge clock) begin
      if (adv.s1) fe1_ff <= req_frame_end;
      if (adv.s2) fe2_ff <= fe1_ff;
      if (adv.s3) fe3_ff <= fe2_ff;
      if (adv.s4) fe4_ff <= fe3_ff;
   end

   // ---------------------------------------------------------------------
   // Channel lanes
   // ---------------------------------------------------------------------
   logic [pcr_pkg::LANES-1:0][pcr_pkg::SAMPLE_W-1:0] samples;
   logic [pcr_pkg::LANES-1:0][pcr_pkg::BYTE_W-1:0]   lane_level;

   assign samples = {req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   for (genvar c = 0; c < pcr_pkg::LANES; c++) begin : g_lane
      pcr_lane u_lane (
         .clock       (clock),
         .adv         (adv),
         .sample_type (sample_type_ff),
         .sample      (samples[c]),
         .gain        ($signed(channel_gains_ff[pcr_pkg::COEF_W*c +: pcr_pkg::COEF_W])),
         .offset      ($signed(channel_offsets_ff[pcr_pkg::COEF_W*c +: pcr_pkg::COEF_W])),
         .level       (lane_level[c])
      );
   end

   // ---------------------------------------------------------------------
   // Merge and output register
   // ---------------------------------------------------------------------
   logic [pcr_pkg::LANES-1:0][pcr_pkg::BYTE_W-1:0] out_bytes;

   pcr_merge u_merge (
      .clock         (clock),
      .load          (rdy_out && v4_ff),
      .lane_level    (lane_level),
      .channel_count (channel_count_ff),
      .layout_map    (layout_map_ff),
      .frame_end     (fe4_ff),
      .out_bytes     (out_bytes),
      .frame_end_out (rsp_frame_end_out)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte_0 = out_bytes[0];
   assign rsp_out_byte_1 = out_bytes[1];
   assign rsp_out_byte_2 = out_bytes[2];
   assign rsp_out_byte_3 = out_bytes[3];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // An accepted word always lands in the first stage.
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted word did not enter stage 1");

   // A word stuck in the last lane stage is held, never dropped.
   a_s4_holds : assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rdy4) |=> v4_ff)
      else $error("stage 4 word lost during output stall");

   // An empty pipeline never refuses input.
   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !v3_ff && !v4_ff) |-> req_ready)
      else $error("empty pipeline not ready");

   // A stalled output word keeps its bytes.
   a_out_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(out_bytes))
      else $error("output bytes changed while stalled");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: pixel contrast to RGBA8 converter
// Self-checking bench. Pixels are pushed through the request channel while a
// predictor in the bench computes each RGBA word from its own copy of the
// CSRs; every returned word is compared field by field in arrival order.
// Directed tests cover the corner cases first, then a random stream runs in
// phases with fresh register settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      RESET_CYCLES   = 7;
   localparam int      SETTLE_CYCLES  = 10;   // pipeline is 5 deep, add margin
   localparam int      RSP_HOLD_CYCLES = 100;
   localparam int      PHASES         = 28;
   localparam int      PHASE_WORDS    = 50;
   localparam int      MAX_REPORTS    = 10;
   localparam longint  TIMEOUT_NS     = 20_000_000;

   // Samples that hit the edges of one type or another.
   localparam logic [31:0] SAMPLE_CORNERS [8] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0000_7FFF, 32'h0000_8000, 32'h0000_00FF, 32'h0000_FFFF
   };

   typedef struct packed {
      logic [3:0][31:0] sample;
      logic             frame_end;
   } pixel_type;

   typedef struct packed {
      logic [3:0][7:0] octet;
      logic            frame_end;
   } rgba_word_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT ports; every input has a known value from time 0.
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [31:0] req_sample_0  = '0;
   logic [31:0] req_sample_1  = '0;
   logic [31:0] req_sample_2  = '0;
   logic [31:0] req_sample_3  = '0;
   logic        req_frame_end = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_out_byte_0;
   logic [7:0]  rsp_out_byte_1;
   logic [7:0]  rsp_out_byte_2;
   logic [7:0]  rsp_out_byte_3;
   logic        rsp_frame_end_out;

   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index     = '0;
   logic [63:0] csr_wdata     = '0;

   always #10 clock = ~clock;

   pixel_contrast_to_rgba8_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_0      (req_sample_0),
      .req_sample_1      (req_sample_1),
      .req_sample_2      (req_sample_2),
      .req_sample_3      (req_sample_3),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte_0    (rsp_out_byte_0),
      .rsp_out_byte_1    (rsp_out_byte_1),
      .rsp_out_byte_2    (rsp_out_byte_2),
      .rsp_out_byte_3    (rsp_out_byte_3),
      .rsp_frame_end_out (rsp_frame_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Shadow copy of the CSRs, starting from their reset values. Updated only
   // when a CSR write handshakes.
   // ------------------------------------------------------------------------
   pcr_pkg::sample_type_type cfg_type    = pcr_pkg::TYPE_U8;
   logic [2:0]               cfg_count   = 3'd1;
   logic [63:0]              cfg_gains   = 64'h1000_1000_1000_1000;
   logic [63:0]              cfg_offsets = 64'h0000_0000_0000_0000;
   logic [7:0]               cfg_layout  = 8'hE4;

   rgba_word_type rgba_expected_q [$];
   int            mismatch_count = 0;

   // Stall control shared with the sender and receiver processes.
   bit send_gaps_on = 1'b1;
   bit rsp_gaps_on  = 1'b1;
   int hold_requests = 0;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint full_scale(pcr_pkg::sample_type_type t);
      case (t)
         pcr_pkg::TYPE_U8:  return 64'd255;
         pcr_pkg::TYPE_U16: return 64'd65535;
         pcr_pkg::TYPE_S16: return 64'd32767;
         default:           return 64'd2147483647;
      endcase
   endfunction

   function automatic longint decode_sample(logic [31:0] raw);
      case (cfg_type)
         pcr_pkg::TYPE_U8:  return longint'(raw[7:0]);
         pcr_pkg::TYPE_U16: return longint'(raw[15:0]);
         pcr_pkg::TYPE_S16: return longint'($signed(raw[15:0]));
         default:           return longint'($signed(raw));
      endcase
   endfunction

   // (s*gain + offset*255)*255 / (max*4096), exact, truncated, clamped.
   function automatic logic [7:0] contrast_code(longint s, longint g, longint o);
      longint num;
      longint q;
      num = (s * g + o * 255) * 255;
      if (num <= 0)
         return 8'd0;
      q = num / (full_scale(cfg_type) * 4096);
      return (q > 255) ? 8'd255 : 8'(q);
   endfunction

   function automatic rgba_word_type predict_rgba(pixel_type px);
      rgba_word_type   w;
      logic [3:0][7:0] chan;
      int              active;
      chan   = {8'd255, 8'd0, 8'd0, 8'd0};
      active = (cfg_count > 3'd4) ? 4 : int'(cfg_count);
      for (int c = 0; c < active; c++)
         chan[c] = contrast_code(decode_sample(px.sample[c]),
                                 longint'($signed(cfg_gains[16*c +: 16])),
                                 longint'($signed(cfg_offsets[16*c +: 16])));
      if (active == 1) begin
         chan[1] = chan[0];
         chan[2] = chan[0];
      end
      // Later channels overwrite earlier ones on a shared byte.
      w.octet = '0;
      for (int c = 0; c < 4; c++)
         w.octet[cfg_layout[2*c +: 2]] = chan[c];
      w.frame_end = px.frame_end;
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------------
   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap(int pct_zero);
      int r;
      r = $urandom_range(0, 99);
      if (r < pct_zero)
         return 0;
      if (r < 96)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] rand_sample();
      if ($urandom_range(0, 6) == 0)
         return SAMPLE_CORNERS[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type px;
      for (int c = 0; c < 4; c++)
         px.sample[c] = rand_sample();
      px.frame_end = ($urandom_range(0, 7) == 0);
      return px;
   endfunction

   // Keep most gains near unity so results land mid-range, not just 0/255.
   function automatic logic [15:0] rand_gain();
      case ($urandom_range(0, 9))
         0, 1:    return 16'($urandom);
         2:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 16'h1800));
      endcase
   endfunction

   function automatic logic [15:0] rand_offset();
      case ($urandom_range(0, 9))
         0, 1:    return 16'($urandom);
         2:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 16'h0200)) - 16'h0100;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   // Write one CSR; drop valid afterwards so back-to-back writes never lower
   // and raise csr_valid in the same step.
   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pcr_pkg::CSR_SAMPLE_TYPE:
            cfg_type = pcr_pkg::sample_type_type'(val[1:0]);
         pcr_pkg::CSR_CHANNEL_COUNT:   cfg_count   = val[2:0];
         pcr_pkg::CSR_CHANNEL_GAINS:   cfg_gains   = val;
         pcr_pkg::CSR_CHANNEL_OFFSETS: cfg_offsets = val;
         pcr_pkg::CSR_LAYOUT_MAP:      cfg_layout  = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_csrs(input pcr_pkg::sample_type_type t,
                                 input logic [2:0] n,
                                 input logic [63:0] g, input logic [63:0] o,
                                 input logic [7:0] lay);
      write_csr(pcr_pkg::CSR_SAMPLE_TYPE, 64'(t));
      write_csr(pcr_pkg::CSR_CHANNEL_COUNT, 64'(n));
      write_csr(pcr_pkg::CSR_CHANNEL_GAINS, g);
      write_csr(pcr_pkg::CSR_CHANNEL_OFFSETS, o);
      write_csr(pcr_pkg::CSR_LAYOUT_MAP, 64'(lay));
   endtask

   // Offer one pixel; hold it until accepted, then maybe idle a while.
   // Valid stays high into the next call when no gap follows.
   task automatic send_pixel(input pixel_type px);
      int gap;
      req_valid     <= 1'b1;
      req_sample_0  <= px.sample[0];
      req_sample_1  <= px.sample[1];
      req_sample_2  <= px.sample[2];
      req_sample_3  <= px.sample[3];
      req_frame_end <= px.frame_end;
      do @(posedge clock); while (!req_ready);
      rgba_expected_q = {rgba_expected_q, predict_rgba(px)};
      gap = send_gaps_on ? pick_gap(60) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every expected word, then let the pipe settle so
   // a following CSR write lands on an idle block.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rgba_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel4(input logic [31:0] s0, input logic [31:0] s1,
                              input logic [31:0] s2, input logic [31:0] s3,
                              input logic fe);
      pixel_type px;
      px.sample    = {s3, s2, s1, s0};
      px.frame_end = fe;
      send_pixel(px);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold whenever a test asks for one.
   // ------------------------------------------------------------------------
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = RSP_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = rsp_gaps_on ? pick_gap(75) : 0;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare each accepted word against the oldest expectation.
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : check_rsp
      rgba_word_type   want;
      logic [3:0][7:0] got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_byte_3, rsp_out_byte_2, rsp_out_byte_1, rsp_out_byte_0};
         if (rgba_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: word %h arrived with none expected", $realtime, got);
         end else begin
            want = rgba_expected_q.pop_front();
            for (int b = 0; b < 4; b++)
               if (got[b] !== want.octet[b])
                  note_mismatch($sformatf("out_byte_%0d", b), want.octet[b], got[b]);
            if (rsp_frame_end_out !== want.frame_end)
               note_mismatch("frame_end_out", 8'(want.frame_end), 8'(rsp_frame_end_out));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Run on the reset CSR values: single channel, unity gain, identity map.
   task automatic test_reset_defaults();
      send_pixel4(32'h0000_0000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 1'b0);
      send_pixel4(32'h0000_00FF, 32'h0, 32'h0, 32'h0, 1'b1);
      send_pixel4(32'hABCD_EF80, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
      send_pixel4(32'hFFFF_FF7F, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1);
      wait_idle();
   endtask

   // Min, max, zero and sign-extension corners for each sample type.
   task automatic test_sample_types();
      for (int t = pcr_pkg::TYPE_U8; t <= pcr_pkg::TYPE_S32; t++) begin
         write_all_csrs(pcr_pkg::sample_type_type'(t), 3'd4,
                        64'h1000_1000_1000_1000, 64'h0, 8'hE4);
         send_pixel4(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_7FFF, 32'h0000_8080, 1'b0);
         send_pixel4(32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0001_0000, 32'h4000_0000, 1'b1);
         wait_idle();
      end
   endtask

   // Extreme Q4.12 gains and offsets, negative results clamping to zero, and
   // the offset scaled by 255 ahead of the type scale.
   task automatic test_gain_offset_extremes();
      write_all_csrs(pcr_pkg::TYPE_U8, 3'd4, 64'h7FFF_8000_0000_1000,
                     64'hFF00_0100_7FFF_8000, 8'hE4);
      send_pixel4(32'hFF, 32'hFF, 32'hFF, 32'hFF, 1'b0);
      send_pixel4(32'h00, 32'h00, 32'h00, 32'h00, 1'b0);
      send_pixel4(32'h80, 32'h80, 32'h80, 32'h80, 1'b1);
      wait_idle();
      write_all_csrs(pcr_pkg::TYPE_U16, 3'd4, 64'h0, 64'h7FFF_0100_8000_7FFF, 8'hE4);
      send_pixel4(32'h0, 32'hFFFF, 32'h0, 32'h1234, 1'b0);
      wait_idle();
   endtask

   // Zero channels, one channel copied into G and B, and counts above four.
   // Also poke the unused CSR indexes, which must change nothing.
   task automatic test_channel_counts();
      logic [2:0] counts [4] = '{3'd0, 3'd1, 3'd5, 3'd7};
      write_all_csrs(pcr_pkg::TYPE_U8, 3'd4, 64'h1000_1000_1000_1000, 64'h0, 8'hE4);
      for (int i = int'(pcr_pkg::CSR_LAYOUT_MAP) + 1; i < 8; i++)
         write_csr(3'(i), {$urandom, $urandom});
      foreach (counts[i]) begin
         write_csr(pcr_pkg::CSR_CHANNEL_COUNT, 64'(counts[i]));
         send_pixel4(32'h11, 32'h22, 32'h33, 32'h44, i[0]);
         wait_idle();
      end
   endtask

   // Several channels onto one byte, plus a plain reversal: highest channel wins, others stay 0.
   task automatic test_layout_collisions();
      logic [7:0] maps [4] = '{8'h00, 8'hFF, 8'h1B, 8'h50};
      write_all_csrs(pcr_pkg::TYPE_U8, 3'd4, 64'h1000_1000_1000_1000, 64'h0, 8'hE4);
      foreach (maps[i]) begin
         write_csr(pcr_pkg::CSR_LAYOUT_MAP, 64'(maps[i]));
         send_pixel4(32'h11, 32'h22, 32'h33, 32'h44, 1'b0);
         wait_idle();
      end
   endtask

   // Hold off the receiver for a long stretch while offering words without
   // gaps, so the pipe fills and req_ready drops; then drain completely.
   task automatic test_backpressure();
      write_all_csrs(pcr_pkg::TYPE_U16, 3'd4, 64'h0C00_1000_1400_0800,
                     64'h0040_FFC0_0000_0010, 8'h9C);
      send_gaps_on = 1'b0;
      rsp_gaps_on  = 1'b1;
      hold_requests++;
      repeat (40) send_pixel(rand_pixel());
      wait_idle();
      send_gaps_on = 1'b1;
   endtask

   // Random stream in phases; each phase gets new CSRs and stall modes.
   // The first two phases pin the register extremes.
   task automatic test_random_stream();
      logic [63:0] g;
      logic [63:0] o;
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            write_all_csrs(pcr_pkg::TYPE_S32, 3'd7, 64'h7FFF_7FFF_7FFF_7FFF,
                           64'h8000_8000_8000_8000, 8'hFF);
         end else if (p == 1) begin
            write_all_csrs(pcr_pkg::TYPE_U8, 3'd0, 64'h8000_8000_8000_8000,
                           64'h7FFF_7FFF_7FFF_7FFF, 8'h00);
         end else begin
            for (int c = 0; c < 4; c++) begin
               g[16*c +: 16] = rand_gain();
               o[16*c +: 16] = rand_offset();
            end
            write_all_csrs(pcr_pkg::sample_type_type'($urandom_range(0, 3)),
                           ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                       : 3'($urandom_range(1, 4)),
                           g, o,
                           ($urandom_range(0, 2) == 0) ? 8'hE4 : 8'($urandom));
         end
         // Leave some phases free of idling on one or both sides.
         send_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on  = ($urandom_range(0, 3) != 0);
         repeat (PHASE_WORDS) send_pixel(rand_pixel());
         wait_idle();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_sample_types();
      test_gain_offset_extremes();
      test_channel_counts();
      test_layout_collisions();
      test_backpressure();
      test_random_stream();
      // wait_idle has already drained the queue and covered the latency
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
